FILE: rtl/clamped_quadratic_position_ramp_core_defines.svh
// Assertion macros for the clamped quadratic position ramp.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CLAMPED_QUADRATIC_POSITION_RAMP_CORE_DEFINES_SVH
`define CLAMPED_QUADRATIC_POSITION_RAMP_CORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define CQPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that, when true, implies another one at the next clock edge.
`define CQPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cqpr_pkg.sv
// Package of the clamped quadratic position ramp: widths, codes and types.
// Used by cqpr_arith and clamped_quadratic_position_ramp_core; depends on nothing.
package cqpr_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned PH_FRAC   = 24;
  localparam int unsigned PH_W      = PH_FRAC + 2;
  localparam int unsigned DEN_W     = POS_W + 10;
  localparam int unsigned ACC_W     = POS_W + PH_FRAC + 2;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [9:0] RANGE_SCALE = 10'd1000;

  localparam logic [PH_W-1:0]    PH_ONE   = PH_W'(1) << PH_FRAC;
  localparam logic [PH_FRAC-1:0] STEP_MAX = '1;

  localparam logic [1:0] CMD_LIFT  = 2'd0;
  localparam logic [1:0] CMD_LOWER = 2'd1;
  localparam logic [1:0] CMD_MOVE  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MAX  = 2'd1;
  localparam logic [1:0] ST_MIN  = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [POS_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [POS_W-1:0] position;
    logic                    position_valid;
    logic                    move_done;
  } out_item_t;

  typedef enum logic {
    ARITH_MUL,
    ARITH_DIV
  } arith_op_e;

  typedef struct packed {
    logic               start;
    arith_op_e          op;
    logic [ACC_W-1:0]   seed;
    logic [PH_FRAC-1:0] mult;
    logic [ACC_W-1:0]   opnd;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic [ACC_W-1:0]   acc;
    logic [PH_FRAC-1:0] quot;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_PREP,
    S_RANGE_MUL,
    S_DIV_CHECK,
    S_DIV,
    S_SQUARE,
    S_SCALE,
    S_RESP
  } state_e;

endpackage

FILE: rtl/cqpr_arith.sv
// Shared iterative arithmetic unit: shift-add multiply and restoring divide.
// One add/subtract per cycle over PH_FRAC steps. Depends on cqpr_pkg.
module cqpr_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cqpr_pkg::arith_req_t req_i,
  output cqpr_pkg::arith_rsp_t rsp_o
);
  import cqpr_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  arith_op_e          op_q, op_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PH_FRAC-1:0] mpl_q, mpl_d;
  logic [ACC_W-1:0]   mcd_q, mcd_d;

  logic [ACC_W-1:0] lhs;
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] sum;
  logic             take;

  // Multiply adds the shifted multiplicand; divide subtracts the divisor.
  always_comb begin
    lhs    = (op_q == ARITH_DIV) ? {acc_q[ACC_W-2:0], 1'b0} : acc_q;
    addend = (op_q == ARITH_DIV) ? ~mcd_q : (mpl_q[0] ? mcd_q : '0);
    sum    = lhs + addend + ACC_W'(op_q == ARITH_DIV);
    take   = ~sum[ACC_W-1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mpl_d  = mpl_q;
    mcd_d  = mcd_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = CNT_W'(PH_FRAC - 1);
      acc_d  = req_i.seed;
      mpl_d  = req_i.mult;
      mcd_d  = req_i.opnd;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (op_q == ARITH_DIV) begin
        acc_d = take ? sum : lhs;
        mpl_d = {mpl_q[PH_FRAC-2:0], take};
      end else begin
        acc_d = sum;
        mpl_d = mpl_q >> 1;
        mcd_d = mcd_q << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ARITH_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mpl_q <= mpl_d;
    mcd_q <= mcd_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.acc  = acc_q;
  assign rsp_o.quot = mpl_q;

endmodule

FILE: rtl/clamped_quadratic_position_ramp_core.sv
// Top level of the clamped quadratic position ramp: sequencer, state and ports.
// Depends on cqpr_pkg, cqpr_arith and clamped_quadratic_position_ramp_core_defines.svh.
//
// An item on the input channel is a command (lift, lower, move to, or tick)
// with an amount. Each item gives exactly one item on the output channel.
// The input is ready only while the sequencer is idle, so one item is worked
// on at a time; the finished item sits in an output register, and the next
// input item is taken while it waits for the receiver.
// A tick while idle, the final tick of a move and a refused command go from decode
// straight to the result state. A move with zero distance or an empty or inverted
// range goes through move preparation only. Any other move runs a 24-step multiply
// for the divisor and, unless the step saturates, the 24-step divide that follows.
// A tick during a move runs two 24-step multiplies. The input is ready again once
// the result is loaded, so the next item is accepted in the cycle after the load at
// the earliest. These multiplies and the divide share the add/subtract unit in
// cqpr_arith. Height limits are written on the plain write port; the user must
// write them only while the block is idle, which the block does not enforce.
// Reset clears the position, ramp state and limits (min 0, max 65536) at once.
// A stalled receiver holds the output item; the next item then waits in its
// final state until the output register is free.
`include "clamped_quadratic_position_ramp_core_defines.svh"

module clamped_quadratic_position_ramp_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  cqpr_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output cqpr_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [cqpr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic signed [cqpr_pkg::POS_W-1:0]   cfg_data_i
);
  import cqpr_pkg::*;

  state_e state_q, state_d;

  logic signed [POS_W-1:0] min_q, max_q;
  logic signed [POS_W-1:0] cur_q, cur_d;
  logic signed [POS_W-1:0] start_q, start_d;
  logic signed [POS_W-1:0] goal_q, goal_d;
  logic [PH_W-1:0]         phase_q, phase_d;
  logic [PH_FRAC-1:0]      step_q, step_d;
  logic                    moving_q, moving_d;

  logic [1:0]              cmd_q;
  logic signed [POS_W-1:0] amount_q;
  logic [POS_W-1:0]        mag_q, mag_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [1:0]              rstatus_q, rstatus_d;
  logic signed [POS_W-1:0] rpos_q, rpos_d;
  logic                    rvalid_q, rvalid_d;
  logic                    rdone_q, rdone_d;

  logic      out_valid_q;
  out_item_t out_item_q;

  logic signed [POS_W:0] target;
  logic signed [POS_W:0] dist_raw;
  logic signed [POS_W:0] dist_abs;
  logic signed [POS_W:0] span;
  logic signed [POS_W:0] delta;
  logic signed [ACC_W-1:0] offset;
  logic                  at_end;
  logic                  out_free;
  logic                  accept;

  arith_req_t arith_req;
  arith_rsp_t arith_rsp;

  cqpr_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign at_end      = (phase_q[PH_W-1:PH_FRAC] != '0);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    unique case (cmd_q)
      CMD_LIFT:  target = (POS_W+1)'(cur_q) + (POS_W+1)'(amount_q);
      CMD_LOWER: target = (POS_W+1)'(cur_q) - (POS_W+1)'(amount_q);
      default:   target = (POS_W+1)'(amount_q);
    endcase
    dist_raw = (POS_W+1)'(start_q) - (POS_W+1)'(goal_q);
    dist_abs = dist_raw[POS_W] ? -dist_raw : dist_raw;
    span     = (POS_W+1)'(max_q) - (POS_W+1)'(min_q);
    delta    = (POS_W+1)'(goal_q) - (POS_W+1)'(start_q);
    offset   = $signed(arith_rsp.acc) >>> PH_FRAC;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (cmd_q == CMD_TICK) begin
          state_d = (moving_q && !at_end) ? S_SQUARE : S_RESP;
        end else begin
          state_d = moving_q ? S_RESP : S_MOVE_PREP;
        end
      end
      S_MOVE_PREP: begin
        if (dist_abs == '0 || span[POS_W] || span == '0) state_d = S_RESP;
        else state_d = S_RANGE_MUL;
      end
      S_RANGE_MUL: begin
        if (arith_rsp.done) state_d = S_DIV_CHECK;
      end
      S_DIV_CHECK: begin
        state_d = (DEN_W'(mag_q) >= den_q) ? S_RESP : S_DIV;
      end
      S_DIV: begin
        if (arith_rsp.done) state_d = S_RESP;
      end
      S_SQUARE: begin
        if (arith_rsp.done) state_d = S_SCALE;
      end
      S_SCALE: begin
        if (arith_rsp.done) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cur_d     = cur_q;
    start_d   = start_q;
    goal_d    = goal_q;
    phase_d   = phase_q;
    step_d    = step_q;
    moving_d  = moving_q;
    mag_d     = mag_q;
    den_d     = den_q;
    rstatus_d = rstatus_q;
    rpos_d    = rpos_q;
    rvalid_d  = rvalid_q;
    rdone_d   = rdone_q;
    arith_req = '0;
    unique case (state_q)
      S_DECODE: begin
        rstatus_d = ST_OK;
        rpos_d    = cur_q;
        rvalid_d  = 1'b0;
        rdone_d   = 1'b0;
        if (cmd_q == CMD_TICK) begin
          if (moving_q && at_end) begin
            rpos_d   = goal_q;
            rvalid_d = 1'b1;
            rdone_d  = 1'b1;
            cur_d    = goal_q;
            moving_d = 1'b0;
          end else if (moving_q) begin
            arith_req.start = 1'b1;
            arith_req.op    = ARITH_MUL;
            arith_req.mult  = phase_q[PH_FRAC-1:0];
            arith_req.opnd  = ACC_W'(phase_q[PH_FRAC-1:0]);
          end
        end else if (moving_q) begin
          rstatus_d = ST_BUSY;
        end else begin
          start_d  = cur_q;
          moving_d = 1'b1;
          if (target >= (POS_W+1)'(max_q)) begin
            goal_d    = max_q;
            rstatus_d = ST_MAX;
          end else if (target <= (POS_W+1)'(min_q)) begin
            goal_d    = min_q;
            rstatus_d = ST_MIN;
          end else begin
            goal_d = target[POS_W-1:0];
          end
        end
      end
      S_MOVE_PREP: begin
        mag_d = dist_abs[POS_W-1:0];
        if (dist_abs == '0) begin
          step_d  = '0;
          phase_d = PH_ONE;
        end else if (span[POS_W] || span == '0) begin
          step_d  = STEP_MAX;
          phase_d = '0;
        end else begin
          arith_req.start = 1'b1;
          arith_req.op    = ARITH_MUL;
          arith_req.mult  = PH_FRAC'(RANGE_SCALE);
          arith_req.opnd  = ACC_W'(span);
        end
      end
      S_RANGE_MUL: begin
        if (arith_rsp.done) den_d = arith_rsp.acc[DEN_W-1:0];
      end
      S_DIV_CHECK: begin
        if (DEN_W'(mag_q) >= den_q) begin
          step_d  = STEP_MAX;
          phase_d = '0;
        end else begin
          arith_req.start = 1'b1;
          arith_req.op    = ARITH_DIV;
          arith_req.seed  = ACC_W'(mag_q);
          arith_req.opnd  = ACC_W'(den_q);
        end
      end
      S_DIV: begin
        if (arith_rsp.done) begin
          step_d  = (arith_rsp.quot == '0) ? PH_FRAC'(1) : arith_rsp.quot;
          phase_d = '0;
        end
      end
      S_SQUARE: begin
        if (arith_rsp.done) begin
          arith_req.start = 1'b1;
          arith_req.op    = ARITH_MUL;
          arith_req.mult  = arith_rsp.acc[2*PH_FRAC-1:PH_FRAC];
          arith_req.opnd  = ACC_W'(delta);
        end
      end
      S_SCALE: begin
        if (arith_rsp.done) begin
          cur_d    = start_q + offset[POS_W-1:0];
          rpos_d   = start_q + offset[POS_W-1:0];
          rvalid_d = 1'b1;
          phase_d  = phase_q + PH_W'(step_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= '0;
      max_q       <= POS_W'(65536);
      cur_q       <= '0;
      start_q     <= '0;
      goal_q      <= '0;
      phase_q     <= '0;
      step_q      <= '0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      start_q  <= start_d;
      goal_q   <= goal_d;
      phase_q  <= phase_d;
      step_q   <= step_d;
      moving_q <= moving_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MIN_HEIGHT) min_q <= cfg_data_i;
        else max_q <= cfg_data_i;
      end
      if (state_q == S_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_item_i.command;
      amount_q <= in_item_i.amount;
    end
    mag_q     <= mag_d;
    den_q     <= den_d;
    rstatus_q <= rstatus_d;
    rpos_q    <= rpos_d;
    rvalid_q  <= rvalid_d;
    rdone_q   <= rdone_d;
    if (state_q == S_RESP && out_free) begin
      out_item_q.status         <= rstatus_q;
      out_item_q.position       <= rpos_q;
      out_item_q.position_valid <= rvalid_q;
      out_item_q.move_done      <= rdone_q;
    end
  end

  `CQPR_ASSERT_NEXT(a_accept_decodes, accept, state_q == S_DECODE, "Accepted item not decoded")
  `CQPR_ASSERT_ALWAYS(a_phase_bound, !phase_q[PH_W-1], "Phase overran its range")
  `CQPR_ASSERT_NEXT(a_step_nonzero, state_q == S_DIV && arith_rsp.done, step_q != '0,
                    "Phase step left at zero after divide")
  `CQPR_ASSERT_NEXT(a_resp_loads, state_q == S_RESP && out_free,
                    out_valid_q && state_q == S_IDLE, "Result not loaded into output register")
  `CQPR_ASSERT_ALWAYS(a_ramp_moving, !(state_q == S_SQUARE || state_q == S_SCALE) || moving_q,
                      "Ramp arithmetic running while idle")

endmodule

FILE: test/tb_clamped_quadratic_position_ramp_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for clamped_quadratic_position_ramp_core: a directed sequence,
// then random episodes of height limits and ramp commands, checked against a predictor.
// Depends on cqpr_pkg and the RTL of the block.

module tb_clamped_quadratic_position_ramp_core;
  import cqpr_pkg::*;

  localparam logic signed [POS_W-1:0] POS_TOP    = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0] POS_BOTTOM = 32'sh80000000;

  class ramp_scoreboard;
    localparam longint UNIT = longint'(1) << PH_FRAC;

    longint    min_limit;
    longint    max_limit;
    longint    cur_pos;
    longint    start_pos;
    longint    goal_pos;
    longint    phase_acc;
    longint    phase_inc;
    bit        moving;
    out_item_t expected_q[$];
    int        failures;
    int        checked;
    int        moves_started;
    int        moves_done;
    int        busy_refusals;
    int        max_clamps;
    int        min_clamps;
    int        setpoints;
    int        commands;
    int        ticks;
    int        limit_writes;

    function new();
      min_limit = 0;
      max_limit = 65536;
      cur_pos   = 0;
      start_pos = 0;
      goal_pos  = 0;
      phase_acc = 0;
      phase_inc = 0;
      moving    = 1'b0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic signed [POS_W-1:0] value);
      if (idx == CFG_MIN_HEIGHT) begin
        min_limit = value;
      end else begin
        max_limit = value;
      end
      limit_writes++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s", $time, what);
      end
    endfunction

    // Phase increment per tick: distance*ONE/(1000*range) in 1..ONE-1, 0 for no travel.
    function longint phase_inc_for(longint travel);
      longint mag;
      longint span;
      longint q;
      mag  = (travel < 0) ? -travel : travel;
      span = max_limit - min_limit;
      if (mag == 0) begin
        return 0;
      end
      if (span <= 0) begin
        return UNIT - 1;
      end
      q = (mag << PH_FRAC) / (longint'(RANGE_SCALE) * span);
      if (q >= UNIT) begin
        return UNIT - 1;
      end
      return (q == 0) ? 1 : q;
    endfunction

    function void note_input(in_item_t it);
      out_item_t want;
      longint    amt;
      longint    target;
      longint    t2;
      want          = '0;
      want.position = cur_pos[POS_W-1:0];
      amt           = it.amount;
      if (it.command == CMD_TICK) begin
        ticks++;
        if (moving) begin
          want.position_valid = 1'b1;
          setpoints++;
          if (phase_acc >= UNIT) begin
            cur_pos        = goal_pos;
            want.move_done = 1'b1;
            moving         = 1'b0;
            moves_done++;
          end else begin
            t2        = (phase_acc * phase_acc) >> PH_FRAC;
            cur_pos   = start_pos + ((t2 * (goal_pos - start_pos)) >>> PH_FRAC);
            phase_acc = phase_acc + phase_inc;
          end
          want.position = cur_pos[POS_W-1:0];
        end
      end else if (moving) begin
        commands++;
        want.status = ST_BUSY;
        busy_refusals++;
      end else begin
        commands++;
        case (it.command)
          CMD_LIFT:  target = cur_pos + amt;
          CMD_LOWER: target = cur_pos - amt;
          default:   target = amt;
        endcase
        if (target >= max_limit) begin
          target      = max_limit;
          want.status = ST_MAX;
          max_clamps++;
        end else if (target <= min_limit) begin
          target      = min_limit;
          want.status = ST_MIN;
          min_clamps++;
        end
        start_pos = cur_pos;
        goal_pos  = target;
        phase_inc = phase_inc_for(start_pos - goal_pos);
        phase_acc = (phase_inc == 0) ? UNIT : 0;
        moving    = 1'b1;
        moves_started++;
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected output item: status=%0d position=%0d valid=%0b done=%0b",
                       got.status, got.position, got.position_valid, got.move_done));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status || got.position !== want.position ||
          got.position_valid !== want.position_valid || got.move_done !== want.move_done) begin
        flag($sformatf({"mismatch: expected status=%0d position=%0d valid=%0b done=%0b, ",
                        "got status=%0d position=%0d valid=%0b done=%0b"},
                       want.status, want.position, want.position_valid, want.move_done,
                       got.status, got.position, got.position_valid, got.move_done));
      end
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  in_item_t                 in_item_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  out_item_t                out_item_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic signed [POS_W-1:0]  cfg_data_i  = '0;

  ramp_scoreboard sb;
  bit             calm          = 1'b0;
  int             hold_requests = 0;
  int             hold_taken    = 0;
  int             hold_left     = 0;
  int             stall_left    = 0;
  int             work_items    = 0;
  int             episodes      = 0;
  int             kind;

  clamped_quadratic_position_ramp_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [POS_W-1:0] rand_amount();
    int unsigned             r;
    logic signed [POS_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return POS_TOP;
        1:       return POS_BOTTOM;
        2:       return '0;
        3:       return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 45) return $urandom;
    v = $urandom_range(0, 1 << 20);
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic logic [1:0] pick_move_command();
    return 2'($urandom_range(CMD_LIFT, CMD_MOVE));
  endfunction

  // The receiver; a hold-off request keeps ready low for a long stretch.
  always @(posedge clk_i) begin
    if (hold_taken != hold_requests) begin
      hold_taken  <= hold_requests;
      hold_left   <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_item_o);
    end
  end

  task automatic send_item(logic [1:0] cmd, logic signed [POS_W-1:0] amt);
    in_item_t it;
    int       gap;
    it.command = cmd;
    it.amount  = amt;
    gap        = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (cmd != CMD_TICK || sb.moving) begin
      work_items++;
    end
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limits(logic signed [POS_W-1:0] low_v, logic signed [POS_W-1:0] high_v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_HEIGHT;
    cfg_data_i <= low_v;
    @(posedge clk_i);
    sb.set_limit(CFG_MIN_HEIGHT, low_v);
    cfg_idx_i  <= CFG_MAX_HEIGHT;
    cfg_data_i <= high_v;
    @(posedge clk_i);
    sb.set_limit(CFG_MAX_HEIGHT, high_v);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic finish_move();
    while (sb.moving) send_item(CMD_TICK, rand_amount());
  endtask

  // Places a small range far from the current position so that a move
  // takes only a few dozen ticks, then runs one move with busy commands mixed in.
  task automatic run_near_episode();
    longint     span;
    longint     reach;
    longint     lo;
    longint     hi;
    longint     cur;
    longint     target;
    longint     amt;
    logic [1:0] op;
    span  = 1 + longint'($urandom_range(0, (1 << $urandom_range(0, 20)) - 1));
    reach = (1000 * span) / $urandom_range(1, 40);
    cur   = sb.cur_pos;
    lo    = cur + reach;
    hi    = lo + span;
    if (hi > longint'(POS_TOP)) begin
      hi = cur - reach;
      lo = hi - span;
    end
    write_limits(lo[POS_W-1:0], hi[POS_W-1:0]);
    target = lo - span + longint'($urandom_range(0, 3 * span));
    op     = pick_move_command();
    case (op)
      CMD_LIFT:  amt = target - cur;
      CMD_LOWER: amt = cur - target;
      default:   amt = target;
    endcase
    if (amt > longint'(POS_TOP) || amt < longint'(POS_BOTTOM)) begin
      op  = CMD_MOVE;
      amt = (target > longint'(POS_TOP)) ? longint'(POS_TOP) :
            (target < longint'(POS_BOTTOM)) ? longint'(POS_BOTTOM) : target;
    end
    if ($urandom_range(0, 4) == 0) begin
      amt = rand_amount();
    end
    send_item(op, amt[POS_W-1:0]);
    while (sb.moving) begin
      send_item(($urandom_range(0, 4) == 0) ? pick_move_command() : CMD_TICK, rand_amount());
    end
    repeat ($urandom_range(0, 2)) send_item(CMD_TICK, rand_amount());
  endtask

  // Inverted or empty range: every move with distance saturates its step.
  task automatic run_folded_episode(bit flat);
    logic signed [POS_W-1:0] a;
    logic signed [POS_W-1:0] b;
    int                      n;
    a = rand_amount();
    b = rand_amount();
    if (flat || a == b) begin
      write_limits(a, a);
    end else if (a > b) begin
      write_limits(a, b);
    end else begin
      write_limits(b, a);
    end
    n = $urandom_range(6, 30);
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 99) < 35) begin
        send_item(pick_move_command(), rand_amount());
      end else begin
        send_item(CMD_TICK, rand_amount());
      end
    end
    finish_move();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_TICK, -32'sd1);
    send_item(CMD_MOVE, '0);
    send_item(CMD_LIFT, 32'sd7);
    send_item(CMD_TICK, '0);
    send_item(CMD_TICK, '0);
    wait_idle();
    write_limits(POS_TOP, POS_BOTTOM);
    send_item(CMD_LIFT, POS_TOP);
    send_item(CMD_TICK, '0);
    send_item(CMD_LOWER, POS_BOTTOM);
    send_item(CMD_TICK, POS_TOP);
    send_item(CMD_TICK, POS_BOTTOM);
    send_item(CMD_LOWER, POS_TOP);
    repeat (3) send_item(CMD_TICK, '0);
    wait_idle();
    write_limits(-32'sd1000, 32'sd1000);
    send_item(CMD_MOVE, '0);
    repeat (3) send_item(CMD_TICK, '0);
    send_item(CMD_MOVE, '0);
    send_item(CMD_TICK, '0);

    while (work_items < 1300) begin
      wait_idle();
      calm <= ($urandom_range(0, 4) == 0);
      if (episodes % 25 == 2) begin
        hold_requests <= hold_requests + 1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        run_near_episode();
      end else if (kind < 85) begin
        run_folded_episode(1'b0);
      end else begin
        run_folded_episode(1'b1);
      end
      episodes++;
    end

    // Full signed range: a long move, only its first ticks are run.
    wait_idle();
    calm <= 1'b0;
    write_limits(POS_BOTTOM, POS_TOP);
    send_item(pick_move_command(), rand_amount());
    repeat (30) begin
      send_item(($urandom_range(0, 3) == 0) ? pick_move_command() : CMD_TICK, rand_amount());
    end
    wait_idle();
    repeat (100) @(posedge clk_i);

    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d expected output items never arrived", sb.pending()));
    end
    $display("Covered %0d commands (%0d moves, %0d busy, %0d clamped high, %0d clamped low)",
             sb.commands, sb.moves_started, sb.busy_refusals, sb.max_clamps, sb.min_clamps);
    $display("and %0d ticks (%0d set-points, %0d finished moves) over %0d limit writes.",
             sb.ticks, sb.setpoints, sb.moves_done, sb.limit_writes);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures in %0d checked output items", sb.failures, sb.checked);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d output items still expected", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cqpr_pkg.sv
rtl/cqpr_arith.sv
rtl/clamped_quadratic_position_ramp_core.sv
test/tb_clamped_quadratic_position_ramp_core.sv
